FILE: src/region_decoded_byte_memory_top_assert.svh
// Assertion macros used by the checker of the region-decoded byte memory.
`ifndef REGION_DECODED_BYTE_MEMORY_TOP_ASSERT_SVH
`define REGION_DECODED_BYTE_MEMORY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RDBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RDBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rdbm_pkg.sv
// Shared types, codes and defaults for the region-decoded byte memory.
package rdbm_pkg;

    localparam int unsigned LANES  = 4;
    localparam int unsigned BANK_W = 2;

    localparam int unsigned RAM_BYTES_DEF   = 65536;
    localparam int unsigned HEAP_BYTES_DEF  = 65536;
    localparam int unsigned STACK_BYTES_DEF = 16384;
    localparam int unsigned VRAM_BYTES_DEF  = 16384;

    localparam logic [31:0] HEAP_BASE_RST  = 32'h1000_0000;
    localparam logic [31:0] STACK_BASE_RST = 32'h2000_0000;
    localparam logic [31:0] VRAM_BASE_RST  = 32'h3000_0000;

    localparam int unsigned FUNC_W = 3;
    localparam logic [FUNC_W-1:0] FUNC_READ8   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ16  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ32  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE8  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_WRITE16 = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_WRITE32 = 3'd5;

    localparam int unsigned CFG_W = 2;
    localparam logic [CFG_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_STACK_BASE = 2'd1;
    localparam logic [CFG_W-1:0] CFG_VRAM_BASE  = 2'd2;

    typedef enum logic [2:0] {
        REG_NONE,
        REG_RAM,
        REG_HEAP,
        REG_STACK,
        REG_VRAM
    } t_region;

    typedef struct packed {
        t_region     region;
        logic [31:0] offset;
    } t_lane_dec;

endpackage

FILE: src/rdbm_ram.sv
// Generic single-port RAM with registered read data.
module rdbm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rdbm_lane.sv
// Address decoder for one byte lane: region match in priority order and region offset.
module rdbm_lane #(
    parameter int unsigned RAM_BYTES   = rdbm_pkg::RAM_BYTES_DEF,
    parameter int unsigned HEAP_BYTES  = rdbm_pkg::HEAP_BYTES_DEF,
    parameter int unsigned STACK_BYTES = rdbm_pkg::STACK_BYTES_DEF,
    parameter int unsigned VRAM_BYTES  = rdbm_pkg::VRAM_BYTES_DEF
) (
    input  logic [31:0]         i_addr,
    input  logic [31:0]         i_heap_base,
    input  logic [31:0]         i_stack_base,
    input  logic [31:0]         i_vram_base,
    output rdbm_pkg::t_lane_dec o_dec
);

    localparam logic [31:0] RamSize   = 32'(RAM_BYTES);
    localparam logic [31:0] HeapSize  = 32'(HEAP_BYTES);
    localparam logic [31:0] StackSize = 32'(STACK_BYTES);
    localparam logic [31:0] VramSize  = 32'(VRAM_BYTES);

    logic [31:0] w_heap_off;
    logic [31:0] w_stack_off;
    logic [31:0] w_vram_off;
    logic        w_in_ram;
    logic        w_in_heap;
    logic        w_in_stack;
    logic        w_in_vram;

    // windows past 2^32 end at the top: the wrapped offset fails the base compare
    assign w_heap_off  = i_addr - i_heap_base;
    assign w_stack_off = i_addr - i_stack_base;
    assign w_vram_off  = i_addr - i_vram_base;

    assign w_in_ram   = i_addr < RamSize;
    assign w_in_heap  = (i_addr >= i_heap_base) && (w_heap_off < HeapSize);
    assign w_in_stack = (i_addr >= i_stack_base) && (w_stack_off < StackSize);
    assign w_in_vram  = (i_addr >= i_vram_base) && (w_vram_off < VramSize);

    always_comb begin
        if (w_in_ram) begin
            o_dec.region = rdbm_pkg::REG_RAM;
            o_dec.offset = i_addr;
        end else if (w_in_heap) begin
            o_dec.region = rdbm_pkg::REG_HEAP;
            o_dec.offset = w_heap_off;
        end else if (w_in_stack) begin
            o_dec.region = rdbm_pkg::REG_STACK;
            o_dec.offset = w_stack_off;
        end else if (w_in_vram) begin
            o_dec.region = rdbm_pkg::REG_VRAM;
            o_dec.offset = w_vram_off;
        end else begin
            o_dec.region = rdbm_pkg::REG_NONE;
            o_dec.offset = '0;
        end
    end

endmodule

FILE: src/rdbm_region.sv
// One memory region split into four byte banks by offset, with lane-to-bank steering.
module rdbm_region #(
    parameter int unsigned       BYTES  = rdbm_pkg::RAM_BYTES_DEF,
    parameter rdbm_pkg::t_region REGION = rdbm_pkg::REG_RAM,
    parameter int unsigned       CLR_W  = 15
) (
    input  logic                                          i_clk,
    input  rdbm_pkg::t_lane_dec [rdbm_pkg::LANES-1:0]     i_dec,
    input  logic [rdbm_pkg::LANES-1:0]                    i_lane_en,
    input  logic                                          i_acc,
    input  logic                                          i_we,
    input  logic [31:0]                                   i_wdata,
    input  logic                                          i_clr,
    input  logic [CLR_W-1:0]                              i_clr_addr,
    output logic [rdbm_pkg::LANES-1:0][7:0]               o_rdata
);

    localparam int unsigned DEPTH = (BYTES + 3) / 4;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [rdbm_pkg::LANES-1:0]      w_hit;
    logic [rdbm_pkg::LANES-1:0][7:0] w_bank_q;

    always_comb begin
        for (int i = 0; i < rdbm_pkg::LANES; i++) begin
            w_hit[i] = i_lane_en[i] && (i_dec[i].region == REGION);
        end
    end

    // consecutive lanes in one region have distinct offset[1:0], so no bank conflicts
    for (genvar b = 0; b < rdbm_pkg::LANES; b++) begin : g_bank
        logic [rdbm_pkg::LANES-1:0] w_sel;
        logic [AW-1:0]              w_addr;
        logic [7:0]                 w_byte;
        logic                       w_en;
        logic                       w_we;
        logic                       w_clr_in;

        always_comb begin
            w_addr = '0;
            w_byte = '0;
            for (int i = 0; i < rdbm_pkg::LANES; i++) begin
                w_sel[i] = w_hit[i] && (i_dec[i].offset[rdbm_pkg::BANK_W-1:0] ==
                                        rdbm_pkg::BANK_W'(b));
                if (w_sel[i]) begin
                    w_addr = i_dec[i].offset[AW+rdbm_pkg::BANK_W-1:rdbm_pkg::BANK_W];
                    w_byte = i_wdata[8*i +: 8];
                end
            end
            w_clr_in = i_clr_addr < CLR_W'(DEPTH);
            if (i_clr) begin
                w_en   = w_clr_in;
                w_we   = w_clr_in;
                w_addr = i_clr_addr[AW-1:0];
                w_byte = '0;
            end else begin
                w_en = i_acc && (|w_sel);
                w_we = w_en && i_we;
            end
        end

        rdbm_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_we    (w_we),
            .i_addr  (w_addr),
            .i_wdata (w_byte),
            .o_rdata (w_bank_q[b])
        );
    end

    always_comb begin
        for (int i = 0; i < rdbm_pkg::LANES; i++) begin
            o_rdata[i] = w_hit[i] ? w_bank_q[i_dec[i].offset[rdbm_pkg::BANK_W-1:0]] : 8'h00;
        end
    end

endmodule

FILE: src/region_decoded_byte_memory_top.sv
// Top level of the region-decoded byte memory: control sequencer, lanes, regions, merge.
//
//   channel   direction  handshake                    payload
//   in        request    i_in_valid / o_in_stall      i_func, i_address, i_write_data
//   out       result     o_out_valid / i_out_stall    o_read_data, o_fault, o_bytes_mapped
//   cfg       write      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Each request passes the steps accept, lane decode, bank access and merge. The four
// lane address decoders and the registered bank read set these steps; a new request is taken only after merge.
// After reset a clearing pass zeroes every bank, one row per cycle, over
// ceil(max region bytes / 4) rows (16384 with defaults); o_in_stall is high meanwhile.
// A stalled result sits in the output register while the next request is taken;
// the merge step waits only if that register is still full.
module region_decoded_byte_memory_top #(
    parameter int unsigned RAM_BYTES   = rdbm_pkg::RAM_BYTES_DEF,
    parameter int unsigned HEAP_BYTES  = rdbm_pkg::HEAP_BYTES_DEF,
    parameter int unsigned STACK_BYTES = rdbm_pkg::STACK_BYTES_DEF,
    parameter int unsigned VRAM_BYTES  = rdbm_pkg::VRAM_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rdbm_pkg::FUNC_W-1:0]  i_func,
    input  logic [31:0]                  i_address,
    input  logic [31:0]                  i_write_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [31:0]                  o_read_data,
    output logic                         o_fault,
    output logic [3:0]                   o_bytes_mapped,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rdbm_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);

    localparam int unsigned LANES   = rdbm_pkg::LANES;
    localparam int unsigned RAM_D   = (RAM_BYTES + 3) / 4;
    localparam int unsigned HEAP_D  = (HEAP_BYTES + 3) / 4;
    localparam int unsigned STACK_D = (STACK_BYTES + 3) / 4;
    localparam int unsigned VRAM_D  = (VRAM_BYTES + 3) / 4;
    localparam int unsigned MAX_D01 = (RAM_D > HEAP_D) ? RAM_D : HEAP_D;
    localparam int unsigned MAX_D23 = (STACK_D > VRAM_D) ? STACK_D : VRAM_D;
    localparam int unsigned MAX_D   = (MAX_D01 > MAX_D23) ? MAX_D01 : MAX_D23;
    localparam int unsigned CLR_W   = $clog2(MAX_D + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ACCESS,
        S_MERGE
    } t_state;

    t_state                            r_state, n_state;
    logic [CLR_W-1:0]                  r_clr_cnt, n_clr_cnt;
    logic [31:0]                       r_heap_base, n_heap_base;
    logic [31:0]                       r_stack_base, n_stack_base;
    logic [31:0]                       r_vram_base, n_vram_base;
    logic                              r_out_valid, n_out_valid;
    logic [rdbm_pkg::FUNC_W-1:0]       r_func, n_func;
    logic [31:0]                       r_wdata, n_wdata;
    logic [LANES-1:0][31:0]            r_lane_addr, n_lane_addr;
    rdbm_pkg::t_lane_dec [LANES-1:0]   r_dec, n_dec;
    logic [31:0]                       r_read_data, n_read_data;
    logic                              r_fault, n_fault;
    logic [3:0]                        r_bytes_mapped, n_bytes_mapped;

    rdbm_pkg::t_lane_dec [LANES-1:0]   w_dec;
    logic [LANES-1:0]                  w_mask;
    logic [LANES-1:0]                  w_mapped;
    logic                              w_is_write;
    logic                              w_we;
    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_clr;
    logic                              w_acc;
    logic [LANES-1:0][7:0]             w_rd_ram, w_rd_heap, w_rd_stack, w_rd_vram;
    logic [LANES-1:0][7:0]             w_bytes;
    logic [31:0]                       w_rdata;

    // lane decoders
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        rdbm_lane #(
            .RAM_BYTES   (RAM_BYTES),
            .HEAP_BYTES  (HEAP_BYTES),
            .STACK_BYTES (STACK_BYTES),
            .VRAM_BYTES  (VRAM_BYTES)
        ) u_lane (
            .i_addr       (r_lane_addr[l]),
            .i_heap_base  (r_heap_base),
            .i_stack_base (r_stack_base),
            .i_vram_base  (r_vram_base),
            .o_dec        (w_dec[l])
        );
    end

    // access size and direction
    always_comb begin
        case (r_func)
            rdbm_pkg::FUNC_READ8,  rdbm_pkg::FUNC_WRITE8:  w_mask = 4'b0001;
            rdbm_pkg::FUNC_READ16, rdbm_pkg::FUNC_WRITE16: w_mask = 4'b0011;
            rdbm_pkg::FUNC_READ32, rdbm_pkg::FUNC_WRITE32: w_mask = 4'b1111;
            default:                                       w_mask = 4'b0000;
        endcase
        w_is_write = (r_func == rdbm_pkg::FUNC_WRITE8) || (r_func == rdbm_pkg::FUNC_WRITE16) ||
                     (r_func == rdbm_pkg::FUNC_WRITE32);
        for (int i = 0; i < LANES; i++) begin
            w_mapped[i] = w_mask[i] && (r_dec[i].region != rdbm_pkg::REG_NONE);
        end
        // 32-bit write with unmapped first byte stores nothing
        w_we = w_is_write && !((r_func == rdbm_pkg::FUNC_WRITE32) && !w_mapped[0]);
    end

    assign w_clr = (r_state == S_CLEAR);
    assign w_acc = (r_state == S_ACCESS);

    rdbm_region #(.BYTES(RAM_BYTES), .REGION(rdbm_pkg::REG_RAM), .CLR_W(CLR_W)) u_ram (
        .i_clk (i_clk), .i_dec (r_dec), .i_lane_en (w_mask), .i_acc (w_acc), .i_we (w_we),
        .i_wdata (r_wdata), .i_clr (w_clr), .i_clr_addr (r_clr_cnt), .o_rdata (w_rd_ram)
    );

    rdbm_region #(.BYTES(HEAP_BYTES), .REGION(rdbm_pkg::REG_HEAP), .CLR_W(CLR_W)) u_heap (
        .i_clk (i_clk), .i_dec (r_dec), .i_lane_en (w_mask), .i_acc (w_acc), .i_we (w_we),
        .i_wdata (r_wdata), .i_clr (w_clr), .i_clr_addr (r_clr_cnt), .o_rdata (w_rd_heap)
    );

    rdbm_region #(.BYTES(STACK_BYTES), .REGION(rdbm_pkg::REG_STACK), .CLR_W(CLR_W)) u_stack (
        .i_clk (i_clk), .i_dec (r_dec), .i_lane_en (w_mask), .i_acc (w_acc), .i_we (w_we),
        .i_wdata (r_wdata), .i_clr (w_clr), .i_clr_addr (r_clr_cnt), .o_rdata (w_rd_stack)
    );

    rdbm_region #(.BYTES(VRAM_BYTES), .REGION(rdbm_pkg::REG_VRAM), .CLR_W(CLR_W)) u_vram (
        .i_clk (i_clk), .i_dec (r_dec), .i_lane_en (w_mask), .i_acc (w_acc), .i_we (w_we),
        .i_wdata (r_wdata), .i_clr (w_clr), .i_clr_addr (r_clr_cnt), .o_rdata (w_rd_vram)
    );

    // merge: each lane is claimed by at most one region, others give zero
    assign w_bytes = w_rd_ram | w_rd_heap | w_rd_stack | w_rd_vram;

    always_comb begin
        case (r_func)
            rdbm_pkg::FUNC_READ8:
                w_rdata = w_mapped[0] ? {24'h0, w_bytes[0]} : 32'h0;
            rdbm_pkg::FUNC_READ16:
                w_rdata = (w_mapped[1:0] == 2'b11) ? {16'h0, w_bytes[1], w_bytes[0]} : 32'h0;
            rdbm_pkg::FUNC_READ32:
                w_rdata = w_mapped[0] ? w_bytes : 32'h0;
            default:
                w_rdata = 32'h0;
        endcase
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_clr_cnt      = r_clr_cnt;
        n_heap_base    = r_heap_base;
        n_stack_base   = r_stack_base;
        n_vram_base    = r_vram_base;
        n_out_valid    = r_out_valid;
        n_func         = r_func;
        n_wdata        = r_wdata;
        n_lane_addr    = r_lane_addr;
        n_dec          = r_dec;
        n_read_data    = r_read_data;
        n_fault        = r_fault;
        n_bytes_mapped = r_bytes_mapped;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_W'(MAX_D - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_func  = i_func;
                    n_wdata = i_write_data;
                    for (int i = 0; i < LANES; i++) begin
                        n_lane_addr[i] = i_address + 32'(i);
                    end
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_dec   = w_dec;
                n_state = S_ACCESS;
            end
            S_ACCESS: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_read_data    = w_rdata;
                    n_fault        = (w_mapped != w_mask);
                    n_bytes_mapped = w_mapped;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rdbm_pkg::CFG_HEAP_BASE:  n_heap_base  = i_cfg_data;
                rdbm_pkg::CFG_STACK_BASE: n_stack_base = i_cfg_data;
                rdbm_pkg::CFG_VRAM_BASE:  n_vram_base  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_cnt    <= '0;
            r_heap_base  <= rdbm_pkg::HEAP_BASE_RST;
            r_stack_base <= rdbm_pkg::STACK_BASE_RST;
            r_vram_base  <= rdbm_pkg::VRAM_BASE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_cnt    <= n_clr_cnt;
            r_heap_base  <= n_heap_base;
            r_stack_base <= n_stack_base;
            r_vram_base  <= n_vram_base;
            r_out_valid  <= n_out_valid;
        end
        r_func         <= n_func;
        r_wdata        <= n_wdata;
        r_lane_addr    <= n_lane_addr;
        r_dec          <= n_dec;
        r_read_data    <= n_read_data;
        r_fault        <= n_fault;
        r_bytes_mapped <= n_bytes_mapped;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_fault        = r_fault;
    assign o_bytes_mapped = r_bytes_mapped;
    assign o_cfg_ready    = 1'b1;

endmodule

FILE: src/rdbm_checker.sv
// Port-level checks for the region-decoded byte memory, bound to the top level.
`include "region_decoded_byte_memory_top_assert.svh"

module rdbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic [31:0] o_read_data,
    input logic        o_fault,
    input logic [3:0]  o_bytes_mapped
);

    logic w_in_acc;
    logic w_lane_run;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_lane_run = (o_bytes_mapped == 4'h0) || (o_bytes_mapped == 4'h1) ||
                        (o_bytes_mapped == 4'h3) || (o_bytes_mapped == 4'hF);

    // banks are being cleared right after reset
    `RDBM_ASSERT_IMPL(a_clear_after_reset, i_clk, i_rst_n, !$past(i_rst_n), o_in_stall, "taken while clearing")

    // a result needs decode and bank access after its request
    `RDBM_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, w_in_acc, !$rose(o_out_valid), "early result")

    // unmapped first byte always reads zero
    `RDBM_ASSERT_IMPL(a_first_unmapped_zero, i_clk, i_rst_n, o_out_valid && !o_bytes_mapped[0], o_read_data == 32'h0, "data on unmapped byte")

    // without a fault the mapped lanes form a run from lane 0, or there are none
    `RDBM_ASSERT_IMPL(a_no_fault_mask, i_clk, i_rst_n, o_out_valid && !o_fault, w_lane_run, "mapped gap without fault")

endmodule

bind region_decoded_byte_memory_top rdbm_checker u_rdbm_checker (.*);
